/* design/lars_pkg.sv */
// ----------------------------------------------------------------------------
// lars_pkg
// shared types, constants and helpers for the local alignment row scorer
// ----------------------------------------------------------------------------
package lars_pkg;

    localparam int MAX_REF = 1024;
    localparam int REF_AW  = $clog2(MAX_REF);
    localparam int CNT_W   = $clog2(MAX_REF + 1);

    localparam int RL_W    = 11;
    localparam int POS_W   = 10;
    localparam int BASE_W  = 8;
    localparam int SCORE_W = 24;
    localparam int IDX_W   = 27;
    localparam int SUM_W   = SCORE_W + 2;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [BASE_W-1:0]  CASE_MASK = 8'hDF;

    localparam int RST_REF_LEN = 1;
    localparam logic [RL_W-1:0]    RST_REF_LENGTH     = RL_W'(RST_REF_LEN);
    localparam logic [6:0]         RST_MATCH_SCORE    = 7'd5;
    localparam logic [7:0]         RST_MISMATCH_SCORE = 8'hFC;
    localparam logic [7:0]         RST_GAP_OPEN       = 8'hF6;
    localparam logic [7:0]         RST_GAP_EXTEND     = 8'hFF;
    localparam logic               RST_EXTEND_MODE    = 1'b1;
    localparam logic [IDX_W-1:0]   RST_ENTRY0         = IDX_W'(RST_REF_LEN + 1);
    localparam logic [IDX_W-1:0]   RST_CELL_INDEX     = IDX_W'(RST_REF_LEN + 2);

    typedef enum logic [1:0] {
        DIR_STOP,
        DIR_DEL,
        DIR_DIAG,
        DIR_INS
    } dir_t;

    typedef enum logic {
        OP_LOAD,
        OP_QUERY
    } op_t;

    typedef enum logic [2:0] {
        REG_REF_LENGTH,
        REG_MATCH_SCORE,
        REG_MISMATCH_SCORE,
        REG_GAP_OPEN,
        REG_GAP_EXTEND,
        REG_EXTEND_MODE
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [RL_W-1:0] ref_length;
        logic [6:0]      match_score;
        logic [7:0]      mismatch_score;
        logic [7:0]      gap_open;
        logic [7:0]      gap_extend;
        logic            extend_mode;
    } cfg_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        dir_t               dir;
        logic [IDX_W-1:0]   start;
    } row_entry_t;

    typedef struct packed {
        logic              en;
        logic [REF_AW-1:0] addr;
        row_entry_t        data;
    } row_wr_t;

    typedef struct packed {
        logic              en;
        logic [REF_AW-1:0] addr;
        logic [BASE_W-1:0] data;
    } ref_wr_t;

    typedef struct packed {
        logic              start;
        logic              first;
        logic [CNT_W-1:0]  len;
        logic [CNT_W-1:0]  fill;
        logic [BASE_W-1:0] qbase;
    } row_cmd_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] col;
        logic             last;
    } issue_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [IDX_W-1:0]   start;
        logic [IDX_W-1:0]   stop;
    } result_t;

    function automatic logic [CNT_W-1:0] row_len(input logic [RL_W-1:0] rl);
        if (int'(rl) > MAX_REF)
        begin
            return CNT_W'(MAX_REF);
        end
        return CNT_W'(rl);
    endfunction

endpackage

/* design/lars_if.sv */
// ----------------------------------------------------------------------------
// lars channel interfaces
// valid/ready channels for query and load items and for alignment results
// ----------------------------------------------------------------------------
interface lars_in_if;
    import lars_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [POS_W-1:0]  ref_position;
    logic [BASE_W-1:0] base;
    logic              first_query;
    logic              last_query;

    modport source (
        output valid, operation, ref_position, base, first_query, last_query,
        input  ready
    );

    modport sink (
        input  valid, operation, ref_position, base, first_query, last_query,
        output ready
    );
endinterface

interface lars_out_if;
    import lars_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] best_score;
    logic [IDX_W-1:0]   best_start_index;
    logic [IDX_W-1:0]   best_end_index;

    modport source (
        output valid, best_score, best_start_index, best_end_index,
        input  ready
    );

    modport sink (
        input  valid, best_score, best_start_index, best_end_index,
        output ready
    );
endinterface

/* design/lars_cfg.sv */
// ----------------------------------------------------------------------------
// lars_cfg
// apb register file holding the scoring and length settings
// ----------------------------------------------------------------------------
module lars_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lars_pkg::CFG_AW-1:0]  paddr,
    input  logic [lars_pkg::CFG_DW-1:0]  pwdata,
    output logic [lars_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    output lars_pkg::cfg_t               cfg
);
    import lars_pkg::*;

    logic [RL_W-1:0] ref_length_reg;
    logic [6:0]      match_score_reg;
    logic [7:0]      mismatch_score_reg;
    logic [7:0]      gap_open_reg;
    logic [7:0]      gap_extend_reg;
    logic            extend_mode_reg;
    logic            wr_en;
    reg_idx_t        sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = reg_idx_t'(paddr[CFG_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_length_reg     <= RST_REF_LENGTH;
            match_score_reg    <= RST_MATCH_SCORE;
            mismatch_score_reg <= RST_MISMATCH_SCORE;
            gap_open_reg       <= RST_GAP_OPEN;
            gap_extend_reg     <= RST_GAP_EXTEND;
            extend_mode_reg    <= RST_EXTEND_MODE;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_REF_LENGTH:     ref_length_reg     <= pwdata[RL_W-1:0];
                REG_MATCH_SCORE:    match_score_reg    <= pwdata[6:0];
                REG_MISMATCH_SCORE: mismatch_score_reg <= pwdata[7:0];
                REG_GAP_OPEN:       gap_open_reg       <= pwdata[7:0];
                REG_GAP_EXTEND:     gap_extend_reg     <= pwdata[7:0];
                REG_EXTEND_MODE:    extend_mode_reg    <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_REF_LENGTH:     prdata = CFG_DW'(ref_length_reg);
            REG_MATCH_SCORE:    prdata = CFG_DW'(match_score_reg);
            REG_MISMATCH_SCORE: prdata = CFG_DW'(mismatch_score_reg);
            REG_GAP_OPEN:       prdata = CFG_DW'(gap_open_reg);
            REG_GAP_EXTEND:     prdata = CFG_DW'(gap_extend_reg);
            REG_EXTEND_MODE:    prdata = CFG_DW'(extend_mode_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.ref_length     = ref_length_reg;
    assign cfg.match_score    = match_score_reg;
    assign cfg.mismatch_score = mismatch_score_reg;
    assign cfg.gap_open       = gap_open_reg;
    assign cfg.gap_extend     = gap_extend_reg;
    assign cfg.extend_mode    = extend_mode_reg;
endmodule

/* design/lars_store.sv */
// ----------------------------------------------------------------------------
// lars_store
// reference base memory and score row memory, registered read data
// ----------------------------------------------------------------------------
module lars_store (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [lars_pkg::REF_AW-1:0]   rd_addr,
    output lars_pkg::row_entry_t          row_rd_data,
    output logic [lars_pkg::BASE_W-1:0]   ref_rd_data,
    input  lars_pkg::row_wr_t             row_wr,
    input  lars_pkg::ref_wr_t             ref_wr
);
    import lars_pkg::*;

    row_entry_t        row_mem [MAX_REF];
    logic [BASE_W-1:0] ref_mem [MAX_REF];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            row_rd_data <= row_mem[rd_addr];
            ref_rd_data <= ref_mem[rd_addr];
        end
        if (row_wr.en)
        begin
            row_mem[row_wr.addr] <= row_wr.data;
        end
        if (ref_wr.en)
        begin
            ref_mem[ref_wr.addr] <= ref_wr.data;
        end
    end
endmodule

/* design/lars_cell.sv */
// ----------------------------------------------------------------------------
// lars_cell
// three stage cell datapath: move scores, deletion chain with write back,
// best score tracking
// ----------------------------------------------------------------------------
module lars_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lars_pkg::cfg_t                cfg,
    input  lars_pkg::row_cmd_t            cmd,
    input  lars_pkg::issue_t              issue,
    input  lars_pkg::row_entry_t          row_rd_data,
    input  logic [lars_pkg::BASE_W-1:0]   ref_rd_data,
    output lars_pkg::row_wr_t             row_wr,
    output logic                          busy,
    output lars_pkg::result_t             best
);
    import lars_pkg::*;

    // row bookkeeping
    logic [IDX_W-1:0]   cidx_reg;
    logic [IDX_W-1:0]   entry0_reg;
    logic [CNT_W-1:0]   fill_lim_reg;
    logic [BASE_W-1:0]  qbase_reg;
    logic [IDX_W-1:0]   c0;
    logic [IDX_W-1:0]   e0;

    // stage a
    logic               a_valid_reg;
    logic [CNT_W-1:0]   a_cell_reg;
    logic               a_last_reg;
    logic [SCORE_W-1:0] diag_reg;
    logic [IDX_W-1:0]   diag_idx_reg;
    logic               in_fill;
    logic [SCORE_W-1:0] above;
    dir_t               adir;
    logic [IDX_W-1:0]   astart;
    logic               eq;
    logic signed [SUM_W-1:0] sub_s;
    logic signed [SUM_W-1:0] gap_ins;
    logic signed [SUM_W-1:0] snp;
    logic signed [SUM_W-1:0] ins;
    logic               ins_wins;

    // stage b
    logic               b_valid_reg;
    logic [CNT_W-1:0]   b_cell_reg;
    logic               b_last_reg;
    logic signed [SUM_W-1:0] b_m1_reg;
    logic [IDX_W-1:0]   b_idx1_reg;
    dir_t               b_dir1_reg;
    logic signed [SUM_W-1:0] del_reg;
    logic [IDX_W-1:0]   prev_start_reg;
    logic               del_wins;
    logic               m1_wins;
    logic signed [SUM_W-1:0] m;
    logic [SCORE_W-1:0] m_sat;
    logic [IDX_W-1:0]   idx;
    dir_t               dir;
    logic               stop;
    logic [SCORE_W-1:0] w_score;
    dir_t               w_dir;
    logic [IDX_W-1:0]   w_start;
    logic signed [SUM_W-1:0] gap_del;
    logic signed [SUM_W-1:0] del_next;

    // stage c
    logic               c_valid_reg;
    logic [SCORE_W-1:0] c_score_reg;
    logic [IDX_W-1:0]   c_idx_reg;
    logic [IDX_W-1:0]   c_cidx_reg;
    logic [SCORE_W-1:0] best_score_reg;
    logic [IDX_W-1:0]   best_start_reg;
    logic [IDX_W-1:0]   best_end_reg;

    assign c0 = cmd.first ? IDX_W'(cmd.len) + IDX_W'(2) : cidx_reg;
    assign e0 = cmd.first ? IDX_W'(cmd.len) + IDX_W'(1) : entry0_reg;

    // stage a: diagonal and insertion candidates
    always_comb
    begin
        in_fill  = a_cell_reg <= fill_lim_reg;
        above    = in_fill ? row_rd_data.score : '0;
        adir     = in_fill ? row_rd_data.dir : DIR_STOP;
        astart   = in_fill ? row_rd_data.start : IDX_W'(a_cell_reg) + IDX_W'(1);
        eq       = ((qbase_reg ^ ref_rd_data) & CASE_MASK) == '0;
        sub_s    = eq ? $signed(SUM_W'(cfg.match_score))
                      : SUM_W'($signed(cfg.mismatch_score));
        gap_ins  = (cfg.extend_mode && adir == DIR_INS) ? SUM_W'($signed(cfg.gap_extend))
                                                         : SUM_W'($signed(cfg.gap_open));
        snp      = $signed({2'b00, diag_reg}) + sub_s;
        ins      = $signed({2'b00, above}) + gap_ins;
        ins_wins = ins > snp;
    end

    // stage b: deletion chain, clamp and stop
    always_comb
    begin
        del_wins = del_reg > b_m1_reg;
        m1_wins  = b_m1_reg > del_reg;
        m        = del_wins ? del_reg : b_m1_reg;
        idx      = del_wins ? prev_start_reg : b_idx1_reg;
        dir      = m1_wins ? b_dir1_reg : DIR_DEL;
        m_sat    = (m > $signed({2'b00, SCORE_MAX})) ? SCORE_MAX : m[SCORE_W-1:0];
        stop     = m <= $signed(SUM_W'(0));
        w_score  = stop ? '0 : m_sat;
        w_dir    = stop ? DIR_STOP : dir;
        w_start  = stop ? cidx_reg + IDX_W'(1) : idx;
        gap_del  = (cfg.extend_mode && w_dir == DIR_DEL) ? SUM_W'($signed(cfg.gap_extend))
                                                          : SUM_W'($signed(cfg.gap_open));
        del_next = $signed({2'b00, w_score}) + gap_del;
    end

    assign row_wr.en         = b_valid_reg;
    assign row_wr.addr       = REF_AW'(b_cell_reg - CNT_W'(1));
    assign row_wr.data.score = w_score;
    assign row_wr.data.dir   = w_dir;
    assign row_wr.data.start = w_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            cidx_reg     <= RST_CELL_INDEX;
            entry0_reg   <= RST_ENTRY0;
            fill_lim_reg <= '0;
        end
        else
        begin
            a_valid_reg <= issue.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg && !stop;
            if (cmd.start)
            begin
                fill_lim_reg <= cmd.fill;
                if (cmd.len == '0)
                begin
                    entry0_reg <= c0;
                    cidx_reg   <= c0 + IDX_W'(1);
                end
                else
                begin
                    entry0_reg <= e0;
                    cidx_reg   <= c0;
                end
            end
            else if (b_valid_reg)
            begin
                if (b_last_reg)
                begin
                    entry0_reg <= cidx_reg + IDX_W'(1);
                    cidx_reg   <= cidx_reg + IDX_W'(2);
                end
                else
                begin
                    cidx_reg <= cidx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_cell_reg <= issue.col;
        a_last_reg <= issue.last;
        if (cmd.start)
        begin
            qbase_reg      <= cmd.qbase;
            diag_reg       <= '0;
            diag_idx_reg   <= e0;
            del_reg        <= '0;
            prev_start_reg <= e0;
        end
        else
        begin
            if (a_valid_reg)
            begin
                diag_reg     <= above;
                diag_idx_reg <= astart;
            end
            if (b_valid_reg)
            begin
                del_reg        <= del_next;
                prev_start_reg <= w_start;
            end
        end
        b_cell_reg  <= a_cell_reg;
        b_last_reg  <= a_last_reg;
        b_m1_reg    <= ins_wins ? ins : snp;
        b_idx1_reg  <= ins_wins ? astart : diag_idx_reg;
        b_dir1_reg  <= (snp <= ins) ? DIR_INS : DIR_DIAG;
        c_score_reg <= m_sat;
        c_idx_reg   <= idx;
        c_cidx_reg  <= cidx_reg;
    end

    // best score tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_start_reg <= '0;
            best_end_reg   <= '0;
        end
        else if (cmd.start && cmd.first)
        begin
            best_score_reg <= '0;
            best_start_reg <= '0;
            best_end_reg   <= '0;
        end
        else if (c_valid_reg && best_score_reg < c_score_reg)
        begin
            best_score_reg <= c_score_reg;
            best_start_reg <= c_idx_reg;
            best_end_reg   <= c_cidx_reg;
        end
    end

    assign busy       = a_valid_reg || b_valid_reg || c_valid_reg;
    assign best.score = best_score_reg;
    assign best.start = best_start_reg;
    assign best.stop  = best_end_reg;
endmodule

/* design/local_alignment_row_scorer.sv */
// ----------------------------------------------------------------------------
// local_alignment_row_scorer
// smith-waterman local alignment with affine gaps over one stored score row
//
//   channel   dir   payload                                          transfer
//   in_ch     in    operation ref_position base first_query last_q   valid&ready
//   out_ch    out   best_score best_start_index best_end_index       valid&ready
//   apb       in    register write/read, 4*index byte addresses      psel&penable
//
// a load is written straight to the reference store; a query base sweeps n
// cells (none if n is zero), n being ref_length capped at 1024, with one row
// memory read-modify-write per reference cell, and the three stage cell
// pipeline then drains; a last query row also loads the output register
// reset needs no clearing pass: a fill count marks written row entries
// a waiting result does not stall loads; a new result waits for out_ch
// ----------------------------------------------------------------------------
module local_alignment_row_scorer (
    input  logic                         clk,
    input  logic                         rst_n,
    lars_in_if.sink                      in_ch,
    lars_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lars_pkg::CFG_AW-1:0]  paddr,
    input  logic [lars_pkg::CFG_DW-1:0]  pwdata,
    output logic [lars_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);
    import lars_pkg::*;

    cfg_t              cfg;
    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [CNT_W-1:0]  rd_cell_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              last_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;

    logic [CNT_W-1:0]  row_n;
    logic [CNT_W-1:0]  row_fill;
    logic              accept;
    logic              is_query;
    logic              in_ready;
    logic              out_load;
    logic              busy;
    row_cmd_t          cmd;
    issue_t            issue;
    row_wr_t           row_wr;
    ref_wr_t           ref_wr;
    row_entry_t        row_rd_data;
    logic [BASE_W-1:0] ref_rd_data;
    logic [REF_AW-1:0] rd_addr;
    result_t           best;

    lars_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lars_store u_store (
        .clk         (clk),
        .rd_en       (issue.valid),
        .rd_addr     (rd_addr),
        .row_rd_data (row_rd_data),
        .ref_rd_data (ref_rd_data),
        .row_wr      (row_wr),
        .ref_wr      (ref_wr)
    );

    lars_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .issue       (issue),
        .row_rd_data (row_rd_data),
        .ref_rd_data (ref_rd_data),
        .row_wr      (row_wr),
        .busy        (busy),
        .best        (best)
    );

    assign row_n    = row_len(cfg.ref_length);
    assign row_fill = in_ch.first_query ? '0 : fill_reg;
    assign is_query = op_t'(in_ch.operation) == OP_QUERY;
    assign accept   = in_ch.valid && in_ready;
    assign rd_addr  = REF_AW'(rd_cell_reg - CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    state_next = (row_n == '0) ? ST_DRAIN : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (rd_cell_reg == len_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = last_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = state_reg == ST_IDLE;
        issue.valid = state_reg == ST_SWEEP;
        issue.col   = rd_cell_reg;
        issue.last  = rd_cell_reg == len_reg;
        out_load    = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);
        cmd.start   = accept && is_query;
        cmd.first   = in_ch.first_query;
        cmd.len     = row_n;
        cmd.fill    = row_fill;
        cmd.qbase   = in_ch.base;
        ref_wr.en   = accept && !is_query && (int'(in_ch.ref_position) < MAX_REF);
        ref_wr.addr = REF_AW'(in_ch.ref_position);
        ref_wr.data = in_ch.base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cell_reg   <= '0;
            len_reg       <= '0;
            fill_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.start)
            begin
                rd_cell_reg <= CNT_W'(1);
                len_reg     <= row_n;
                last_reg    <= in_ch.last_query;
                fill_reg    <= (row_fill > row_n) ? row_fill : row_n;
            end
            else if (issue.valid)
            begin
                rd_cell_reg <= rd_cell_reg + CNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= best;
        end
    end

    assign in_ch.ready             = in_ready;
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.best_score       = out_data_reg.score;
    assign out_ch.best_start_index = out_data_reg.start;
    assign out_ch.best_end_index   = out_data_reg.stop;

    a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !busy)
        else $error("item taken while cell pipeline busy");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (row_wr.en && issue.valid) |-> (row_wr.addr != rd_addr))
        else $error("row write collides with row read");

    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> (rd_cell_reg != '0 && rd_cell_reg <= len_reg))
        else $error("cell issued outside row");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> last_reg)
        else $error("result stage without last query");
endmodule

/* test/row_scorer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_scorer_checker
// watches the register port and both channels of the local alignment row
// scorer, keeps its own copy of the reference store, the score row and the
// best-hit tracking, and checks every result transfer against the oldest
// predicted best hit
// ----------------------------------------------------------------------------
module row_scorer_checker
    import lars_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lars_in_if                in_ch,
    lars_out_if               out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output int                errors,
    output int                pending
);

    localparam longint SCORE_CAP = longint'(SCORE_MAX);

    cfg_t               cfg;
    logic [BASE_W-1:0]  ref_mem   [MAX_REF];
    logic [SCORE_W-1:0] score_row [MAX_REF+1];
    dir_t               dir_row   [MAX_REF+1];
    logic [IDX_W-1:0]   start_row [MAX_REF+1];
    logic [IDX_W-1:0]   cell_idx;
    result_t            best;
    result_t            due;
    result_t            best_due_q [$];

    function automatic int cells_in_row();
        return (cfg.ref_length > RL_W'(MAX_REF)) ? MAX_REF : int'(cfg.ref_length);
    endfunction

    function automatic longint gap_penalty(dir_t held, dir_t run);
        if (cfg.extend_mode && held == run)
        begin
            return longint'($signed(cfg.gap_extend));
        end
        return longint'($signed(cfg.gap_open));
    endfunction

    task automatic clear_rows();
        for (int i = 0; i <= MAX_REF; i++)
        begin
            score_row[i] = '0;
            dir_row[i]   = DIR_STOP;
            start_row[i] = IDX_W'(i + 1);
        end
        start_row[0] = IDX_W'(cells_in_row() + 1);
        cell_idx     = IDX_W'(cells_in_row() + 2);
        best         = '0;
    endtask

    task automatic sweep_row(input logic [BASE_W-1:0] qbase);
        int               n;
        longint           diag, del, above, snp, ins, m;
        logic [IDX_W-1:0] diag_idx, idx, old_idx;
        dir_t             move;
        n        = cells_in_row();
        diag     = 0;
        del      = 0;
        diag_idx = start_row[0];
        for (int i = 1; i <= n; i++)
        begin
            if (((qbase ^ ref_mem[i-1]) & CASE_MASK) == '0)
            begin
                snp = longint'(cfg.match_score);
            end
            else
            begin
                snp = longint'($signed(cfg.mismatch_score));
            end
            above    = longint'(score_row[i]);
            ins      = above + gap_penalty(dir_row[i], DIR_INS);
            snp      = snp + diag;
            diag     = above;
            m        = (ins > snp) ? ins : snp;
            old_idx  = start_row[i];
            idx      = (ins > snp) ? old_idx : diag_idx;
            diag_idx = old_idx;
            if (m > del)
            begin
                move = (snp <= ins) ? DIR_INS : DIR_DIAG;
            end
            else
            begin
                move = DIR_DEL;
            end
            // strict compare: a tie keeps the insertion/diagonal start
            if (del > m)
            begin
                idx = start_row[i-1];
                m   = del;
            end
            if (m > SCORE_CAP)
            begin
                m = SCORE_CAP;
            end
            if (m <= 0)
            begin
                dir_row[i]   = DIR_STOP;
                score_row[i] = '0;
                start_row[i] = cell_idx + 1'b1;
            end
            else
            begin
                dir_row[i]   = move;
                score_row[i] = m[SCORE_W-1:0];
                start_row[i] = idx;
                if (longint'(best.score) < m)
                begin
                    best.score = m[SCORE_W-1:0];
                    best.start = idx;
                    best.stop  = cell_idx;
                end
            end
            del      = longint'(score_row[i]) + gap_penalty(dir_row[i], DIR_DEL);
            cell_idx = cell_idx + 1'b1;
        end
        start_row[0] = cell_idx;
        cell_idx     = cell_idx + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.ref_length     = RST_REF_LENGTH;
            cfg.match_score    = RST_MATCH_SCORE;
            cfg.mismatch_score = RST_MISMATCH_SCORE;
            cfg.gap_open       = RST_GAP_OPEN;
            cfg.gap_extend     = RST_GAP_EXTEND;
            cfg.extend_mode    = RST_EXTEND_MODE;
            for (int i = 0; i < MAX_REF; i++)
            begin
                ref_mem[i] = '0;
            end
            clear_rows();
            best_due_q.delete();
            errors = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (best_due_q.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, score %0d start %0d end %0d",
                             $time, out_ch.best_score, out_ch.best_start_index,
                             out_ch.best_end_index);
                    errors++;
                end
                else
                begin
                    due = best_due_q.pop_front();
                    if (out_ch.best_score !== due.score)
                    begin
                        $display("%0t: best_score expected %0d actual %0d",
                                 $time, due.score, out_ch.best_score);
                        errors++;
                    end
                    if (out_ch.best_start_index !== due.start)
                    begin
                        $display("%0t: best_start_index expected %0d actual %0d",
                                 $time, due.start, out_ch.best_start_index);
                        errors++;
                    end
                    if (out_ch.best_end_index !== due.stop)
                    begin
                        $display("%0t: best_end_index expected %0d actual %0d",
                                 $time, due.stop, out_ch.best_end_index);
                        errors++;
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[CFG_AW-1:2]))
                    REG_REF_LENGTH:     cfg.ref_length     = pwdata[RL_W-1:0];
                    REG_MATCH_SCORE:    cfg.match_score    = pwdata[6:0];
                    REG_MISMATCH_SCORE: cfg.mismatch_score = pwdata[7:0];
                    REG_GAP_OPEN:       cfg.gap_open       = pwdata[7:0];
                    REG_GAP_EXTEND:     cfg.gap_extend     = pwdata[7:0];
                    REG_EXTEND_MODE:    cfg.extend_mode    = pwdata[0];
                    default:            ;
                endcase
            end

            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.operation == OP_LOAD)
                begin
                    ref_mem[in_ch.ref_position] = in_ch.base;
                end
                else
                begin
                    if (in_ch.first_query)
                    begin
                        clear_rows();
                    end
                    sweep_row(in_ch.base);
                    if (in_ch.last_query)
                    begin
                        best_due_q.push_back(best);
                    end
                end
            end
        end
        pending = best_due_q.size();
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives reference loads and query rows into the local alignment row scorer
// under a series of scoring setups, with random gaps on the input side and
// random stalls on the result side; a checker beside the block predicts each
// best hit and compares every result transfer
// ----------------------------------------------------------------------------
module tb;
    import lars_pkg::*;

    localparam int DRAIN_PAD = 20;
    localparam int PRELOAD   = 200;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic              pready;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    int                err_count;
    int                pending_count;
    bit                idle_on = 1'b1;
    int                cur_len = 1;

    lars_in_if  in_ch ();
    lars_out_if out_ch ();

    local_alignment_row_scorer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    row_scorer_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .errors  (err_count),
        .pending (pending_count)
    );

    always #5 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    // mostly nucleotides in either case, some arbitrary bytes
    function automatic logic [BASE_W-1:0] pick_base();
        logic [BASE_W-1:0] nuc;
        if ($urandom_range(0, 9) < 3)
        begin
            return BASE_W'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 3))
            0:       nuc = "A";
            1:       nuc = "C";
            2:       nuc = "G";
            default: nuc = "T";
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            nuc = nuc ^ 8'h20;
        end
        return nuc;
    endfunction

    task automatic push_base(input op_t op, input logic [POS_W-1:0] pos,
                             input logic [BASE_W-1:0] b, input logic first,
                             input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= op;
        in_ch.ref_position <= pos;
        in_ch.base         <= b;
        in_ch.first_query  <= first;
        in_ch.last_query   <= last;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // all results back, then room for a row still sweeping without one
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (((cur_len > MAX_REF) ? MAX_REF : cur_len) + DRAIN_PAD) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [CFG_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({r, 2'b00});
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_scoring(input int len, input int match_pts, input int mism_pts,
                                   input int open_pts, input int ext_pts, input bit mode);
        write_reg(REG_REF_LENGTH, CFG_DW'(len));
        write_reg(REG_MATCH_SCORE, CFG_DW'(match_pts));
        write_reg(REG_MISMATCH_SCORE, {24'd0, 8'(mism_pts)});
        write_reg(REG_GAP_OPEN, {24'd0, 8'(open_pts)});
        write_reg(REG_GAP_EXTEND, {24'd0, 8'(ext_pts)});
        write_reg(REG_EXTEND_MODE, CFG_DW'(mode));
        cur_len = len;
    endtask

    task automatic run_traffic(input int n_items);
        int sent;
        int rows;
        int kind;
        sent = 0;
        while (sent < n_items)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 99);
            if (kind < 70)
            begin
                // a full alignment, sometimes after a few reference updates
                repeat ($urandom_range(0, 2))
                begin
                    push_base(OP_LOAD, POS_W'($urandom_range(0, 1023)), pick_base(),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    sent++;
                end
                rows = $urandom_range(1, 6);
                for (int r = 0; r < rows; r++)
                begin
                    push_base(OP_QUERY, POS_W'($urandom_range(0, 1023)), pick_base(),
                              (r == 0) && ($urandom_range(0, 9) != 0),
                              (r == rows - 1) || ($urandom_range(0, 9) == 0));
                    sent++;
                end
            end
            else if (kind < 85)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    push_base(OP_LOAD, POS_W'($urandom_range(0, 1023)), pick_base(),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            else
            begin
                // stray row: continues or abandons whatever alignment is open
                push_base(OP_QUERY, POS_W'($urandom_range(0, 1023)), pick_base(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                in_ch.valid <= 1'b0;
                while (pending_count != 0) @(negedge clk);
                @(negedge clk);
            end
        end
    endtask

    initial
    begin
        int stall;
        bit hold;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            hold  = idle_on && ($urandom_range(0, 1) == 1);
            if (stall > 0 || hold)
            begin
                out_ch.ready <= 1'b0;
                if (hold)
                begin
                    do @(posedge clk); while (!out_ch.valid);
                    @(negedge clk);
                end
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
            @(negedge clk);
        end
    end

    initial
    begin
        in_ch.valid        = 1'b0;
        in_ch.operation    = OP_LOAD;
        in_ch.ref_position = '0;
        in_ch.base         = '0;
        in_ch.first_query  = 1'b0;
        in_ch.last_query   = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setup, one reference cell
        push_base(OP_LOAD, 10'd0, "A", 1'b0, 1'b0);
        push_base(OP_LOAD, 10'd1023, 8'hFF, 1'b1, 1'b1);
        push_base(OP_QUERY, 10'd1023, "a", 1'b1, 1'b1);
        push_base(OP_QUERY, 10'd0, 8'h00, 1'b0, 1'b0);
        push_base(OP_QUERY, 10'd0, 8'hC1, 1'b0, 1'b0);
        push_base(OP_QUERY, 10'd0, 8'h41, 1'b0, 1'b1);
        push_base(OP_QUERY, 10'd0, 8'hFF, 1'b1, 1'b1);
        quiesce();

        // leading reference cells written in order; every length used stays within them
        for (int i = 0; i < PRELOAD; i++)
        begin
            push_base(OP_LOAD, POS_W'(i), pick_base(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        for (int p = 0; p < 15; p++)
        begin
            quiesce();
            case (p)
                0:       program_scoring(8, 127, -128, -128, -128, 1'b1);
                1:       program_scoring(0, 0, 127, 0, 0, 1'b0);
                2:       program_scoring(PRELOAD, 5, -4, -10, -1, 1'b1);
                3:       program_scoring(PRELOAD - 40, 127, 127, 0, 0, 1'b1);
                4:       program_scoring(16, 0, -128, -128, 0, 1'b0);
                default: program_scoring(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40),
                                         $urandom_range(0, 127),
                                         int'($urandom_range(0, 255)) - 128,
                                         -int'($urandom_range(0, 128)),
                                         -int'($urandom_range(0, 128)),
                                         1'($urandom_range(0, 1)));
            endcase
            // rows carry on across the register change
            push_base(OP_QUERY, POS_W'($urandom_range(0, 1023)), pick_base(), 1'b0, 1'b1);
            run_traffic((p == 2 || p == 3) ? 6 : ((p < 5) ? 20 : 22));
        end

        quiesce();
        if (err_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
